### src/psre_pkg.sv
// ----------------------------------------------------------------------------
// psre_pkg: shared types and constants of the PNG stored RGB encoder
// Item and result records, command and register codes, default limits.
// ----------------------------------------------------------------------------
package psre_pkg;

   localparam int DEF_MAX_WIDTH  = 8192;
   localparam int DEF_MAX_HEIGHT = 8192;
   localparam int QUEUE_DEPTH    = 4;
   localparam int CFG_W          = 14;

   localparam logic CMD_START = 1'b0;
   localparam logic CMD_PIXEL = 1'b1;

   localparam logic CSR_WIDTH  = 1'b0;
   localparam logic CSR_HEIGHT = 1'b1;

   typedef struct packed {
      logic        is_start;
      logic [23:0] pixel;
   } item_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       run_end;
      logic       file_end;
      logic       misuse;
   } result_type;

endpackage

### src/psre_front.sv
// ----------------------------------------------------------------------------
// psre_front: input queue of the PNG stored RGB encoder
// Accepts items, marks frame starts and holds them until the back end is free.
// ----------------------------------------------------------------------------
module psre_front import psre_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   input  logic        req_command,
   input  logic [23:0] req_pixel,
   output logic        req_full,
   output logic        q_valid,
   output item_type    q_item,
   input  logic        q_pop
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   item_type           mem_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ff, wr_in, rd_ff, rd_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic               do_push;
   item_type           new_item;

   assign req_full = (cnt_ff == CNT_W'(QUEUE_DEPTH));
   assign q_valid  = (cnt_ff != '0);
   assign q_item   = mem_ff[rd_ff];
   assign do_push  = req_push && !req_full;

   always_comb begin
      new_item.is_start = (req_command == CMD_START);
      new_item.pixel    = req_pixel;
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (do_push) begin
         wr_in = (wr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ff + 1'b1;
      end
      if (q_pop) begin
         rd_in = (rd_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ff + 1'b1;
      end
      if (do_push && !q_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (!do_push && q_pop) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ff] <= new_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule

### src/psre_back.sv
// ----------------------------------------------------------------------------
// psre_back: byte sequencer of the PNG stored RGB encoder
// Turns queued items into PNG bytes, one a cycle while the output is not stalled, with CRC-32 and Adler-32.
// ----------------------------------------------------------------------------
module psre_back import psre_pkg::*; #(
   parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic [CFG_W-1:0] cfg_width,
   input  logic [CFG_W-1:0] cfg_height,
   input  logic             q_valid,
   input  item_type         q_item,
   output logic             q_pop,
   output logic             rsp_valid,
   output result_type       rsp_data,
   input  logic             rsp_pop
);

   localparam int W_W   = $clog2(MAX_WIDTH + 1);
   localparam int H_W   = $clog2(MAX_HEIGHT + 1);
   localparam int COL_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int RAW_W = $clog2(MAX_HEIGHT * (3 * MAX_WIDTH + 1) + 1);
   localparam int PRD_W = H_W + W_W + 2;

   typedef enum logic [4:0] {
      S_IDLE  = 5'b00001,
      S_START = 5'b00010,
      S_PIX   = 5'b00100,
      S_TAIL  = 5'b01000,
      S_MIS   = 5'b10000
   } bk_state_type;

   function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] b);
      logic [31:0] r;
      r = c ^ {24'b0, b};
      for (int k = 0; k < 8; k++) begin
         r = r[0] ? ((r >> 1) ^ 32'hEDB88320) : (r >> 1);
      end
      return r;
   endfunction

   function automatic logic [CFG_W-1:0] clamp_dim(input logic [CFG_W-1:0] v,
                                                   input logic [CFG_W-1:0] m);
      logic [CFG_W-1:0] r;
      r = v;
      if (v == '0) r = CFG_W'(1);
      else if (v > m) r = m;
      return r;
   endfunction

   bk_state_type       state_ff, state_in;
   logic [5:0]         idx_ff, idx_in;
   logic [1:0]         slot_ff, slot_in;
   logic [2:0]         hdr_ff, hdr_in;
   logic [23:0]        pix_ff, pix_in;
   logic [31:0]        crc_ff, crc_in;
   logic [15:0]        alo_ff, alo_in, ahi_ff, ahi_in;
   logic [15:0]        blk_ff, blk_in;
   logic [RAW_W-1:0]   left_ff, left_in;
   logic [COL_W-1:0]   col_ff, col_in;
   logic               open_ff, open_in;
   logic [W_W-1:0]     w_ff, w_in, w_cur;
   logic [H_W-1:0]     h_ff, h_in;
   logic [RAW_W-1:0]   raw_ff, raw_in;
   logic [15:0]        blocks_ff, blocks_in;
   logic [31:0]        idat_ff, idat_in;
   logic               out_valid_ff, out_valid_in;
   result_type         out_ff, out_in;

   logic               adv, emit, is_put, crc_rst, last, fend, mis;
   logic [7:0]         byte_v, data_v;
   logic [31:0]        crc_n, w32, h32, r32, left32, s32, rem32, a32;
   logic               ge;
   logic [15:0]        blen, nlen;
   logic [16:0]        lo_sum, hi_sum;
   logic [15:0]        lo_n, hi_n;
   logic [W_W+1:0]     w3p1;
   logic [PRD_W-1:0]   prod;
   logic [COL_W:0]     col_nxt;
   logic [COL_W-1:0]   col_upd;

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;
   assign adv       = !out_valid_ff || rsp_pop;
   assign q_pop     = (state_ff == S_IDLE) && q_valid;

   // Frame size arithmetic, one step a cycle from the sizes latched at start.
   always_comb begin
      w3p1      = {2'b00, w_ff} + {1'b0, w_ff, 1'b0} + (W_W+2)'(1);
      prod      = PRD_W'(h_ff) * PRD_W'(w3p1);
      raw_in    = RAW_W'(prod);
      r32       = 32'(raw_ff);
      a32       = {16'b0, r32[31:16]};
      s32       = a32 + {16'b0, r32[15:0]};
      ge        = (s32 >= 32'd65535);
      rem32     = ge ? s32 - 32'd65535 : s32;
      blocks_in = 16'(a32 + 32'(ge) + 32'(rem32 != '0));
      idat_in   = r32 + {blocks_ff, 2'b00} + 32'(blocks_ff) + 32'd6;
   end

   always_comb begin
      w_cur   = W_W'(clamp_dim(cfg_width, CFG_W'(MAX_WIDTH)));
      w32     = 32'(w_ff);
      h32     = 32'(h_ff);
      crc_n   = ~crc_ff;
      left32  = 32'(left_ff);
      blen    = (left32 > 32'd65535) ? 16'hFFFF : left32[15:0];
      nlen    = ~blen;
      case (slot_ff)
         2'd0:    data_v = 8'h00;
         2'd1:    data_v = pix_ff[23:16];
         2'd2:    data_v = pix_ff[15:8];
         default: data_v = pix_ff[7:0];
      endcase
      lo_sum  = {1'b0, alo_ff} + {9'b0, data_v};
      lo_n    = (lo_sum >= 17'd65521) ? 16'(lo_sum - 17'd65521) : lo_sum[15:0];
      hi_sum  = {1'b0, ahi_ff} + {1'b0, lo_n};
      hi_n    = (hi_sum >= 17'd65521) ? 16'(hi_sum - 17'd65521) : hi_sum[15:0];
      col_nxt = {1'b0, col_ff} + (COL_W+1)'(1);
      col_upd = (16'(col_nxt) >= 16'(w_cur)) ? '0 : col_nxt[COL_W-1:0];

      state_in = state_ff;
      idx_in   = idx_ff;
      slot_in  = slot_ff;
      hdr_in   = hdr_ff;
      pix_in   = pix_ff;
      alo_in   = alo_ff;
      ahi_in   = ahi_ff;
      blk_in   = blk_ff;
      left_in  = left_ff;
      col_in   = col_ff;
      open_in  = open_ff;
      w_in     = w_ff;
      h_in     = h_ff;
      emit     = 1'b0;
      is_put   = 1'b0;
      crc_rst  = 1'b0;
      last     = 1'b0;
      fend     = 1'b0;
      mis      = 1'b0;
      byte_v   = 8'h00;

      case (state_ff)
         S_IDLE: begin
            if (q_valid) begin
               pix_in = q_item.pixel;
               idx_in = '0;
               hdr_in = '0;
               if (q_item.is_start) begin
                  state_in = S_START;
                  w_in = W_W'(clamp_dim(cfg_width, CFG_W'(MAX_WIDTH)));
                  h_in = H_W'(clamp_dim(cfg_height, CFG_W'(MAX_HEIGHT)));
               end else if (open_ff) begin
                  state_in = S_PIX;
                  slot_in  = (col_ff == '0) ? 2'd0 : 2'd1;
               end else begin
                  state_in = S_MIS;
               end
            end
         end
         S_START: begin
            if (adv) begin
               emit   = 1'b1;
               idx_in = idx_ff + 1'b1;
               is_put = ((idx_ff >= 6'd12) && (idx_ff <= 6'd28)) || (idx_ff >= 6'd37);
               crc_rst = (idx_ff == 6'd12) || (idx_ff == 6'd37);
               case (idx_ff)
                  6'd0:  byte_v = 8'h89;
                  6'd1:  byte_v = 8'h50;
                  6'd2:  byte_v = 8'h4E;
                  6'd3:  byte_v = 8'h47;
                  6'd4:  byte_v = 8'h0D;
                  6'd5:  byte_v = 8'h0A;
                  6'd6:  byte_v = 8'h1A;
                  6'd7:  byte_v = 8'h0A;
                  6'd11: byte_v = 8'h0D;
                  6'd12: byte_v = 8'h49;
                  6'd13: byte_v = 8'h48;
                  6'd14: byte_v = 8'h44;
                  6'd15: byte_v = 8'h52;
                  6'd16: byte_v = w32[31:24];
                  6'd17: byte_v = w32[23:16];
                  6'd18: byte_v = w32[15:8];
                  6'd19: byte_v = w32[7:0];
                  6'd20: byte_v = h32[31:24];
                  6'd21: byte_v = h32[23:16];
                  6'd22: byte_v = h32[15:8];
                  6'd23: byte_v = h32[7:0];
                  6'd24: byte_v = 8'h08;
                  6'd25: byte_v = 8'h02;
                  6'd29: byte_v = crc_n[31:24];
                  6'd30: byte_v = crc_n[23:16];
                  6'd31: byte_v = crc_n[15:8];
                  6'd32: byte_v = crc_n[7:0];
                  6'd33: byte_v = idat_ff[31:24];
                  6'd34: byte_v = idat_ff[23:16];
                  6'd35: byte_v = idat_ff[15:8];
                  6'd36: byte_v = idat_ff[7:0];
                  6'd37: byte_v = 8'h49;
                  6'd38: byte_v = 8'h44;
                  6'd39: byte_v = 8'h41;
                  6'd40: byte_v = 8'h54;
                  6'd41: byte_v = 8'h78;
                  6'd42: byte_v = 8'h01;
                  default: byte_v = 8'h00;
               endcase
               if (idx_ff == 6'd42) begin
                  last     = 1'b1;
                  state_in = S_IDLE;
                  open_in  = 1'b1;
                  col_in   = '0;
                  blk_in   = '0;
                  left_in  = raw_ff;
                  alo_in   = 16'd1;
                  ahi_in   = 16'd0;
               end
            end
         end
         S_PIX: begin
            if (adv) begin
               emit   = 1'b1;
               is_put = 1'b1;
               if (blk_ff == '0) begin
                  // Stored block header ahead of the block's first byte.
                  hdr_in = hdr_ff + 1'b1;
                  case (hdr_ff)
                     3'd0:    byte_v = {7'b0, (left32 <= 32'd65535)};
                     3'd1:    byte_v = blen[7:0];
                     3'd2:    byte_v = blen[15:8];
                     3'd3:    byte_v = nlen[7:0];
                     default: byte_v = nlen[15:8];
                  endcase
                  if (hdr_ff == 3'd4) begin
                     hdr_in = '0;
                     blk_in = blen;
                  end
               end else begin
                  byte_v  = data_v;
                  alo_in  = lo_n;
                  ahi_in  = hi_n;
                  blk_in  = blk_ff - 1'b1;
                  left_in = left_ff - 1'b1;
                  if (left_ff == RAW_W'(1)) begin
                     state_in = S_TAIL;
                     idx_in   = '0;
                     col_in   = col_upd;
                  end else if (slot_ff == 2'd3) begin
                     state_in = S_IDLE;
                     last     = 1'b1;
                     col_in   = col_upd;
                  end else begin
                     slot_in = slot_ff + 1'b1;
                  end
               end
            end
         end
         S_TAIL: begin
            if (adv) begin
               emit    = 1'b1;
               idx_in  = idx_ff + 1'b1;
               is_put  = (idx_ff <= 6'd3) || ((idx_ff >= 6'd12) && (idx_ff <= 6'd15));
               crc_rst = (idx_ff == 6'd12);
               case (idx_ff)
                  6'd0:  byte_v = ahi_ff[15:8];
                  6'd1:  byte_v = ahi_ff[7:0];
                  6'd2:  byte_v = alo_ff[15:8];
                  6'd3:  byte_v = alo_ff[7:0];
                  6'd4:  byte_v = crc_n[31:24];
                  6'd5:  byte_v = crc_n[23:16];
                  6'd6:  byte_v = crc_n[15:8];
                  6'd7:  byte_v = crc_n[7:0];
                  6'd12: byte_v = 8'h49;
                  6'd13: byte_v = 8'h45;
                  6'd14: byte_v = 8'h4E;
                  6'd15: byte_v = 8'h44;
                  6'd16: byte_v = crc_n[31:24];
                  6'd17: byte_v = crc_n[23:16];
                  6'd18: byte_v = crc_n[15:8];
                  6'd19: byte_v = crc_n[7:0];
                  default: byte_v = 8'h00;
               endcase
               if (idx_ff == 6'd19) begin
                  last     = 1'b1;
                  fend     = 1'b1;
                  state_in = S_IDLE;
                  open_in  = 1'b0;
               end
            end
         end
         S_MIS: begin
            if (adv) begin
               emit     = 1'b1;
               last     = 1'b1;
               mis      = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (is_put) begin
         crc_in = crc_byte(crc_rst ? 32'hFFFFFFFF : crc_ff, byte_v);
      end else begin
         crc_in = crc_ff;
      end

      out_in          = out_ff;
      out_valid_in    = out_valid_ff && !rsp_pop;
      if (emit) begin
         out_valid_in     = 1'b1;
         out_in.out_byte  = byte_v;
         out_in.run_end   = last;
         out_in.file_end  = fend;
         out_in.misuse    = mis;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff    <= idx_in;
      slot_ff   <= slot_in;
      hdr_ff    <= hdr_in;
      pix_ff    <= pix_in;
      w_ff      <= w_in;
      h_ff      <= h_in;
      raw_ff    <= raw_in;
      blocks_ff <= blocks_in;
      idat_ff   <= idat_in;
      out_ff    <= out_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         crc_ff       <= 32'hFFFFFFFF;
         alo_ff       <= 16'd1;
         ahi_ff       <= 16'd0;
         blk_ff       <= '0;
         left_ff      <= '0;
         col_ff       <= '0;
         open_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         crc_ff       <= crc_in;
         alo_ff       <= alo_in;
         ahi_ff       <= ahi_in;
         blk_ff       <= blk_in;
         left_ff      <= left_in;
         col_ff       <= col_in;
         open_ff      <= open_in;
         out_valid_ff <= out_valid_in;
      end
   end

   a_fend_ends_run: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_ff.file_end |-> out_ff.run_end)
      else $error("file end without run end");

   a_pix_has_bytes: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_PIX |-> left_ff != '0 && hdr_ff <= 3'd4)
      else $error("pixel work with no raw bytes left");

   a_pop_when_idle: assert property (@(posedge clock) disable iff (reset)
      q_pop |=> state_ff != S_IDLE)
      else $error("item taken but sequencer stayed idle");

endmodule

### src/png_stored_rgb_encoder.sv
// ----------------------------------------------------------------------------
// png_stored_rgb_encoder: PNG byte stream from raster RGB pixels
// Uncompressed zlib stored blocks, CRC-32 per chunk, Adler-32 over raw data.
// ----------------------------------------------------------------------------
//  channel   ports                                     beat moves when
//  request   req_push req_full req_command req_pixel   req_push & !req_full
//  response  rsp_empty rsp_pop rsp_out_byte + flags    rsp_pop & !rsp_empty
//  config    csr_we csr_index csr_data                 csr_we
//
// The back end gives one byte a cycle while the output is not stalled; the
// idle sequencer takes each item from the input queue, then a pixel gives
// its bytes, a block header leads each stored block, the frame close follows
// the last raw byte and a start item gives the PNG header. Reset clears the
// sequencer state, checksums and queue pointers and restores both size
// registers to one. A stalled response side holds the output register; the
// four-entry input queue keeps taking beats until it fills, and each side stalls on its own.
// ----------------------------------------------------------------------------
module png_stored_rgb_encoder import psre_pkg::*; #(
   parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_push,
   output logic             req_full,
   input  logic             req_command,
   input  logic [23:0]      req_pixel,
   output logic             rsp_empty,
   input  logic             rsp_pop,
   output logic [7:0]       rsp_out_byte,
   output logic             rsp_run_end,
   output logic             rsp_file_end,
   output logic             rsp_misuse,
   input  logic             csr_we,
   input  logic             csr_index,
   input  logic [CFG_W-1:0] csr_data
);

   // Size registers as written; the sequencer clamps them where used.
   logic [CFG_W-1:0] width_ff, height_ff;
   item_type         q_item;
   logic             q_valid, q_pop, rsp_valid;
   result_type       rsp_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= CFG_W'(1);
         height_ff <= CFG_W'(1);
      end else if (csr_we) begin
         case (csr_index)
            CSR_WIDTH:  width_ff  <= csr_data;
            CSR_HEIGHT: height_ff <= csr_data;
            default:    width_ff  <= width_ff;
         endcase
      end
   end

   // The front end queues incoming beats and marks frame starts.
   psre_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_push    (req_push),
      .req_command (req_command),
      .req_pixel   (req_pixel),
      .req_full    (req_full),
      .q_valid     (q_valid),
      .q_item      (q_item),
      .q_pop       (q_pop)
   );

   // The back end expands each item into its bytes and keeps the checksums.
   psre_back #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg_width  (width_ff),
      .cfg_height (height_ff),
      .q_valid    (q_valid),
      .q_item     (q_item),
      .q_pop      (q_pop),
      .rsp_valid  (rsp_valid),
      .rsp_data   (rsp_data),
      .rsp_pop    (rsp_pop)
   );

   assign rsp_empty    = !rsp_valid;
   assign rsp_out_byte = rsp_data.out_byte;
   assign rsp_run_end  = rsp_data.run_end;
   assign rsp_file_end = rsp_data.file_end;
   assign rsp_misuse   = rsp_data.misuse;

endmodule
